// ===== sv/tgarle_pkg.sv =====
// Shared constants and register codes for the TGA run-length pixel decoder.
package tgarle_pkg;

    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 8;

    // Packet header: top bit marks a run, low seven bits hold length minus one
    localparam int unsigned  RUN_BIT   = 7;
    localparam logic [7:0]   LEN_MASK  = 8'h7F;

    localparam logic [2:0]         BPP_RESET    = 3'd4;
    localparam logic [DATA_W-1:0]  PIXELS_RESET = 32'd1;
    localparam logic               COMP_RESET   = 1'b1;

    typedef enum logic [1:0] {
        REG_BPP        = 2'd0,
        REG_PIXELS     = 2'd1,
        REG_COMPRESSED = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_index_t;

endpackage

// ===== sv/tga_rle_pixel_decoder.sv =====
// Output: a pixel's last byte loads the registered output beat as it is accepted.
// Throughput: one data byte per cycle while the pixel side takes beats; a pixel
// waiting on a stalled output holds back every byte, header bytes included.
// Header and leading pixel bytes update counters and the gather register only.
// Reset (rst_n low, asynchronous): registers return to 4 bytes per pixel, one
// pixel per image, compressed mode, and the decoder waits for a packet header.
module tga_rle_pixel_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tgarle_pkg::ADDR_W-1:0] paddr,
    input  logic [tgarle_pkg::DATA_W-1:0] pwdata,
    output logic [tgarle_pkg::DATA_W-1:0] prdata,
    output logic                          pready,
    // byte stream in
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [7:0]                    data_byte,
    // pixels out
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [7:0]                    red,
    output logic [7:0]                    green,
    output logic [7:0]                    blue,
    output logic [7:0]                    alpha,
    output logic [7:0]                    repeat_count,
    output logic                          image_done
);
    import tgarle_pkg::*;

    // configuration registers
    logic [2:0]        bpp_reg;
    logic [DATA_W-1:0] image_pixels_reg;
    logic              compressed_reg;

    // decoder state
    logic              expect_header_reg, expect_header_next;
    logic              run_packet_reg, run_packet_next;
    logic [6:0]        packet_left_reg, packet_left_next;
    logic [1:0]        byte_pos_reg, byte_pos_next;
    logic [23:0]       gather_reg, gather_next;
    logic [DATA_W-1:0] pixels_left_reg, pixels_left_next;

    // output register
    logic              out_valid_reg;
    logic [7:0]        red_reg, green_reg, blue_reg, alpha_reg, count_reg;
    logic              done_reg;

    logic              accept;
    logic              cfg_write;
    reg_index_t        cfg_index;

    logic              size4;
    logic [1:0]        last_pos;
    logic              is_header;
    logic              is_finish;
    logic [DATA_W-1:0] pixels_avail;
    logic [COUNT_W-1:0] raw_count;
    logic [COUNT_W-1:0] clip_count;
    logic [7:0]        red_next, alpha_next;
    logic              done_next;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[3:2]);

    always_comb
    begin
        case (cfg_index)
            REG_BPP:        prdata = {{(DATA_W-3){1'b0}}, bpp_reg};
            REG_PIXELS:     prdata = image_pixels_reg;
            REG_COMPRESSED: prdata = {{(DATA_W-1){1'b0}}, compressed_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg          <= BPP_RESET;
            image_pixels_reg <= PIXELS_RESET;
            compressed_reg   <= COMP_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_BPP:        bpp_reg          <= pwdata[2:0];
                REG_PIXELS:     image_pixels_reg <= pwdata;
                REG_COMPRESSED: compressed_reg   <= pwdata[0];
                default:        ;
            endcase
        end
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // sizes of three or less act as three bytes, four or more as four
    assign size4     = bpp_reg[2];
    assign last_pos  = size4 ? 2'd3 : 2'd2;
    assign is_header = compressed_reg && expect_header_reg;
    assign is_finish = !is_header && (byte_pos_reg >= last_pos);

    // an empty counter loads the image size; a zero size acts as one pixel
    always_comb
    begin
        if (pixels_left_reg != '0)
            pixels_avail = pixels_left_reg;
        else if (image_pixels_reg == '0)
            pixels_avail = {{(DATA_W-1){1'b0}}, 1'b1};
        else
            pixels_avail = image_pixels_reg;
    end

    assign raw_count  = (compressed_reg && run_packet_reg) ?
                        ({1'b0, packet_left_reg} + 8'd1) : 8'd1;
    assign clip_count = ({{(DATA_W-COUNT_W){1'b0}}, raw_count} > pixels_avail) ?
                        pixels_avail[COUNT_W-1:0] : raw_count;
    assign done_next  = (pixels_avail == {{(DATA_W-COUNT_W){1'b0}}, clip_count});
    assign red_next   = size4 ? gather_reg[23:16] : data_byte;
    assign alpha_next = size4 ? data_byte : 8'd0;

    always_comb
    begin
        expect_header_next = expect_header_reg;
        run_packet_next    = run_packet_reg;
        packet_left_next   = packet_left_reg;
        byte_pos_next      = byte_pos_reg;
        gather_next        = gather_reg;
        pixels_left_next   = pixels_left_reg;

        if (is_header)
        begin
            run_packet_next    = data_byte[RUN_BIT];
            packet_left_next   = data_byte[6:0] & LEN_MASK[6:0];
            expect_header_next = 1'b0;
            byte_pos_next      = 2'd0;
        end
        else if (!is_finish)
        begin
            case (byte_pos_reg)
                2'd0:    gather_next[7:0]   = data_byte;
                2'd1:    gather_next[15:8]  = data_byte;
                2'd2:    gather_next[23:16] = data_byte;
                default: ;
            endcase
            byte_pos_next = byte_pos_reg + 2'd1;
        end
        else
        begin
            byte_pos_next    = 2'd0;
            pixels_left_next = pixels_avail - {{(DATA_W-COUNT_W){1'b0}}, clip_count};
            if (!compressed_reg || run_packet_reg)
            begin
                expect_header_next = 1'b1;
                packet_left_next   = 7'd0;
            end
            else if (packet_left_reg == 7'd0)
                expect_header_next = 1'b1;
            else
                packet_left_next = packet_left_reg - 7'd1;
            // end of image: drop the rest of any packet and rearm
            if (done_next)
            begin
                expect_header_next = 1'b1;
                packet_left_next   = 7'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_header_reg <= 1'b1;
            run_packet_reg    <= 1'b0;
            packet_left_reg   <= 7'd0;
            byte_pos_reg      <= 2'd0;
            gather_reg        <= 24'd0;
            pixels_left_reg   <= '0;
        end
        else if (accept)
        begin
            expect_header_reg <= expect_header_next;
            run_packet_reg    <= run_packet_next;
            packet_left_reg   <= packet_left_next;
            byte_pos_reg      <= byte_pos_next;
            gather_reg        <= gather_next;
            pixels_left_reg   <= pixels_left_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && is_finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // payload loads only with a finished pixel
    always_ff @(posedge clk)
    begin
        if (accept && is_finish)
        begin
            red_reg   <= red_next;
            green_reg <= gather_reg[15:8];
            blue_reg  <= gather_reg[7:0];
            alpha_reg <= alpha_next;
            count_reg <= clip_count;
            done_reg  <= done_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign red          = red_reg;
    assign green        = green_reg;
    assign blue         = blue_reg;
    assign alpha        = alpha_reg;
    assign repeat_count = count_reg;
    assign image_done   = done_reg;

    a_finish_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_finish) |=> out_valid_reg)
        else $error("finished pixel did not raise a beat");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (count_reg != 8'd0 && count_reg <= 8'd128))
        else $error("repeat count out of range");

    a_done_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && done_reg) |-> (pixels_left_reg == '0 && expect_header_reg))
        else $error("image end did not rearm the decoder");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !in_ready)
        else $error("byte taken while output stalled");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the TGA run-length pixel decoder.
`timescale 1ns / 1ps

module testbench;

    import tgarle_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_count;
        logic       image_done;
    } pixel_t;

    typedef enum bit {ROW_BYTE, ROW_CFG} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        reg_index_t  idx;
        logic [31:0] value;
        bit          typed;
        pixel_t      want;
    } row_t;

    localparam int PLAN_ROWS    = 36;
    localparam int RANDOM_BYTES = 1130;
    localparam int LAST_BYTES   = 120;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              in_valid;
    logic              in_ready;
    logic [7:0]        data_byte;
    logic              out_valid;
    logic              out_ready;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        alpha;
    logic [7:0]        repeat_count;
    logic              image_done;

    // decoder prediction: registers and stream state
    logic [2:0]  reg_bpp;
    logic [31:0] reg_pixels;
    logic        reg_comp;
    logic        hdr_due;
    logic        run_mode;
    logic [7:0]  pkt_left;
    logic [1:0]  byte_pos;
    logic [23:0] gather;
    logic [31:0] pix_left;

    pixel_t pixels_due[$];
    int     mismatches = 0;
    int     fed = 0;
    bit     quiet = 1'b0;
    row_t   plan [PLAN_ROWS];

    tga_rle_pixel_decoder dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endtask

    task automatic decode_byte(input logic [7:0] b, output bit emit, output pixel_t px);
        bit          wide;
        logic [1:0]  last_pos;
        logic [31:0] n;
        wide = (reg_bpp >= 3'd4);
        last_pos = wide ? 2'd3 : 2'd2;
        emit = 1'b0;
        px = '0;
        if (reg_comp && hdr_due)
        begin
            run_mode = b[RUN_BIT];
            pkt_left = b & LEN_MASK;
            hdr_due = 1'b0;
            byte_pos = 2'd0;
        end
        else if (byte_pos < last_pos)
        begin
            gather[byte_pos*8 +: 8] = b;
            byte_pos = byte_pos + 2'd1;
        end
        else
        begin
            // a position at or past the last index finishes the pixel
            emit = 1'b1;
            px.blue = gather[7:0];
            px.green = gather[15:8];
            px.red = wide ? gather[23:16] : b;
            px.alpha = wide ? b : 8'h00;
            byte_pos = 2'd0;
            if (pix_left == 0)
                pix_left = (reg_pixels == 0) ? 32'd1 : reg_pixels;
            if (!reg_comp)
            begin
                n = 32'd1;
                hdr_due = 1'b1;
                pkt_left = 8'd0;
            end
            else if (run_mode)
            begin
                n = pkt_left + 32'd1;
                hdr_due = 1'b1;
                pkt_left = 8'd0;
            end
            else
            begin
                n = 32'd1;
                if (pkt_left == 0)
                    hdr_due = 1'b1;
                else
                    pkt_left = pkt_left - 8'd1;
            end
            // clip at the image end and drop what is left of the packet
            if (n > pix_left)
                n = pix_left;
            pix_left = pix_left - n;
            if (pix_left == 0)
            begin
                hdr_due = 1'b1;
                pkt_left = 8'd0;
            end
            px.repeat_count = n[7:0];
            px.image_done = (pix_left == 0);
        end
    endtask

    task automatic apb_xfer(input bit wr, input reg_index_t idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_reg(input reg_index_t idx, input logic [31:0] v);
        logic [31:0] rd;
        logic [31:0] want;
        apb_xfer(1'b1, idx, v, rd);
        case (idx)
            REG_BPP:        reg_bpp = v[2:0];
            REG_PIXELS:     reg_pixels = v;
            REG_COMPRESSED: reg_comp = v[0];
            default:        ;
        endcase
        if (idx != REG_UNUSED)
        begin
            apb_xfer(1'b0, idx, '0, rd);
            want = (idx == REG_BPP) ? {29'd0, reg_bpp} :
                   (idx == REG_PIXELS) ? reg_pixels : {31'd0, reg_comp};
            if (rd !== want)
                note_error($sformatf("readback of %s: expected %h, got %h",
                                     idx.name(), want, rd));
        end
    endtask

    task automatic feed(input logic [7:0] b, input bit typed, input pixel_t want);
        int     gap;
        bit     emit;
        pixel_t px;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (!in_ready);
        fed++;
        decode_byte(b, emit, px);
        if (typed)
            pixels_due.push_back(want);
        else if (emit)
            pixels_due.push_back(px);
    endtask

    // hold the stream until every pixel has left, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [7:0] next_byte();
        int r;
        logic [6:0] len;
        r = $urandom_range(0, 99);
        if (reg_comp && hdr_due)
        begin
            if (r < 60)
                len = 7'($urandom_range(0, 3));
            else if (r < 90)
                len = 7'($urandom_range(4, 15));
            else
                len = 7'($urandom_range(16, 127));
            return {1'($urandom_range(0, 1)), len};
        end
        if (r < 10)
            return 8'h00;
        if (r < 20)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic row_t data_row(input logic [7:0] b);
        row_t r;
        r.kind = ROW_BYTE;
        r.idx = REG_UNUSED;
        r.value = {24'd0, b};
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic row_t check_row(input logic [7:0] b, input pixel_t want);
        row_t r;
        r = data_row(b);
        r.typed = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic row_t reg_row(input reg_index_t idx, input logic [31:0] v);
        row_t r;
        r = data_row(8'h00);
        r.kind = ROW_CFG;
        r.idx = idx;
        r.value = v;
        return r;
    endfunction

    // stalls on the pixel side
    initial
    begin : pixel_sink
        int hold;
        out_ready = 1'b0;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin : pixel_check
        pixel_t got;
        pixel_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {red, green, blue, alpha, repeat_count, image_done};
            if (pixels_due.size() == 0)
                note_error($sformatf({"pixel with none expected: ",
                                      "r=%h g=%h b=%h a=%h n=%0d done=%b"},
                                     red, green, blue, alpha, repeat_count, image_done));
            else
            begin
                want = pixels_due.pop_front();
                if (got !== want)
                    note_error($sformatf({"pixel mismatch: expected r=%h g=%h b=%h a=%h n=%0d ",
                                          "done=%b, got r=%h g=%h b=%h a=%h n=%0d done=%b"},
                                         want.red, want.green, want.blue, want.alpha,
                                         want.repeat_count, want.image_done,
                                         red, green, blue, alpha, repeat_count, image_done));
            end
        end
    end

    initial
    begin
        int          r;
        int          nbytes;
        logic [31:0] v;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        data_byte = 8'h00;

        reg_bpp = BPP_RESET;
        reg_pixels = PIXELS_RESET;
        reg_comp = COMP_RESET;
        hdr_due = 1'b1;
        run_mode = 1'b0;
        pkt_left = 8'd0;
        byte_pos = 2'd0;
        gather = 24'd0;
        pix_left = 32'd0;

        plan = '{
            // reset settings: one 4-byte run pixel closes a one-pixel image
            data_row(8'h80),
            data_row(8'h11), data_row(8'h22), data_row(8'h33),
            check_row(8'h44, {8'h33, 8'h22, 8'h11, 8'h44, 8'd1, 1'b1}),
            reg_row(REG_BPP, 32'd3),
            reg_row(REG_PIXELS, 32'd3),
            // longest run, clipped to the image
            data_row(8'hFF),
            data_row(8'h01), data_row(8'h80),
            check_row(8'hFF, {8'hFF, 8'h80, 8'h01, 8'h00, 8'd3, 1'b1}),
            // longest literal, cut short at the image end
            data_row(8'h7F),
            data_row(8'h00), data_row(8'h00),
            check_row(8'h00, {8'h00, 8'h00, 8'h00, 8'h00, 8'd1, 1'b0}),
            data_row(8'hAA), data_row(8'h55), data_row(8'h00),
            data_row(8'h12), data_row(8'h34),
            check_row(8'h56, {8'h56, 8'h34, 8'h12, 8'h00, 8'd1, 1'b1}),
            // raw pixels, odd size, zero image size, write beyond the map
            reg_row(REG_COMPRESSED, 32'd0),
            reg_row(REG_BPP, 32'd7),
            reg_row(REG_PIXELS, 32'd0),
            reg_row(REG_UNUSED, 32'hFFFF_FFFF),
            data_row(8'h01), data_row(8'h02), data_row(8'h03),
            // shrink the pixel while its fourth byte is due
            reg_row(REG_BPP, 32'd2),
            check_row(8'h04, {8'h04, 8'h02, 8'h01, 8'h00, 8'd1, 1'b1}),
            // back to packets: a header comes first
            reg_row(REG_COMPRESSED, 32'd1),
            reg_row(REG_PIXELS, 32'd2),
            data_row(8'h81),
            data_row(8'h09), data_row(8'h08),
            data_row(8'h07)
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                settle();
                set_reg(plan[i].idx, plan[i].value);
            end
            else
                feed(plan[i].value[7:0], plan[i].typed, plan[i].want);
        end

        while (fed < RANDOM_BYTES)
        begin
            settle();
            quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            v = (r < 40) ? 32'd3 : (r < 80) ? 32'd4 : $urandom_range(0, 7);
            if ($urandom_range(0, 1))
                set_reg(REG_BPP, ({$urandom} & ~32'h7) | v);
            r = $urandom_range(0, 99);
            v = (r < 10) ? 32'd0 : (r < 80) ? $urandom_range(1, 24) :
                (r < 95) ? $urandom_range(25, 300) : 32'd1;
            if ($urandom_range(0, 1))
                set_reg(REG_PIXELS, v);
            v = ($urandom_range(0, 3) != 0) ? 32'd1 : 32'd0;
            if ($urandom_range(0, 1))
                set_reg(REG_COMPRESSED, ({$urandom} & ~32'h1) | v);
            if ($urandom_range(0, 9) == 0)
                set_reg(REG_UNUSED, $urandom);
            nbytes = $urandom_range(60, 140);
            repeat (nbytes) feed(next_byte(), 1'b0, '0);
        end

        // largest image size last, so it cannot starve later images
        settle();
        quiet = 1'b0;
        set_reg(REG_PIXELS, 32'hFFFF_FFFF);
        repeat (LAST_BYTES) feed(next_byte(), 1'b0, '0);

        in_valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
